// ----- rtl/core/tsc_mass_deposit_grid_macros.svh -----
// assertion macros for the tsc mass deposit grid
`ifndef TSC_MASS_DEPOSIT_GRID_MACROS_SVH
`define TSC_MASS_DEPOSIT_GRID_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSC_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("tsc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TSC_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tsc assertion failed");

`endif

// ----- rtl/core/tsc_pkg.sv -----
// shared types and constants of the tsc mass deposit grid
`timescale 1ns / 1ps
package tsc_pkg;

  // weight constants, 24 fraction bits: Q3.24 for the halves, Q0.24 for THREEQ
  localparam logic [26:0] HALF_Q24      = 27'd8388608;
  localparam logic [26:0] THREEHALF_Q24 = 27'd25165824;
  localparam logic [23:0] THREEQ_Q24    = 24'd12582912;

  // 1.5 cells in Q.32, window start offset
  localparam logic signed [35:0] WIN_OFS = 36'sh1_8000_0000;

  // register indexes
  localparam logic [1:0] REG_CPL   = 2'd0;
  localparam logic [1:0] REG_SHIFT = 2'd1;
  localparam logic [1:0] REG_NORM  = 2'd2;

  // sequencer states
  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_GMUL  = 13'b0000000000100,
    S_MOD   = 13'b0000000001000,
    S_WGT   = 13'b0000000010000,
    S_MMUL  = 13'b0000000100000,
    S_WXY   = 13'b0000001000000,
    S_WP    = 13'b0000010000000,
    S_MH    = 13'b0000100000000,
    S_ML    = 13'b0001000000000,
    S_WR    = 13'b0010000000000,
    S_RD    = 13'b0100000000000,
    S_RDO   = 13'b1000000000000
  } state_t;

endpackage

// ----- rtl/core/tsc_mass_deposit_grid.sv -----
// top level of the tsc mass deposit grid: sequencer, config and grid memory
//
// Input beats (in_valid / in_stall) are either a deposit (kind 0) or a read
// (kind 1). A deposit scales the position per axis with one multiply, reduces
// the base cell modulo GRID_N with a reciprocal multiply and one correction,
// forms the four axis weights, then walks the 4x4x4 window with one
// read-modify-write per cell through the shared multiplier, plus an x-y
// weight step per row. A deposit holds in_stall until the walk ends and
// gives no result. A read goes through the grid's registered read and the
// output register and puts one density beat on the out channel (out_valid /
// out_stall); a read index past the grid returns 0. The walk is paced by the
// shared multiplier and the single grid write port. After reset the grid is
// cleared one cell a cycle, all GRID_N cubed cells, with in_stall high;
// config writes are taken at any time. When the receiver stalls, the result
// beat holds and the next read waits for the output register to free up.
`timescale 1ns / 1ps
`include "tsc_mass_deposit_grid_macros.svh"
module tsc_mass_deposit_grid
  import tsc_pkg::*;
#(
  parameter int GRID_N = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_mass,
  input  logic [14:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_density
);

  localparam int DEPTH = GRID_N * GRID_N * GRID_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_N);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(GRID_N));

  state_t state_r, state_nxt;

  // config registers
  logic [31:0]        cpl_r;
  logic signed [17:0] shift_r;
  logic [31:0]        norm_r;

  // latched item
  logic        kind_r;
  logic [31:0] pos_r [3];
  logic [31:0] mass_r;
  logic [14:0] cell_idx_r;

  // setup datapath
  logic [1:0]        axis_r;
  logic [31:0]       frac_r;
  logic signed [3:0] lo_r;
  logic [31:0]       base_r;
  logic [31:0]       quo_r;
  logic              mod_ph_r;
  logic [CW-1:0]     fc_r [3];
  logic [23:0]       wgt_r [3][4];
  logic [31:0]       mhi_r, mlo_r;

  // window walk
  logic [1:0]    i_r, j_r, k_r;
  logic [CW-1:0] cx_r, cy_r, cz_r;
  logic [23:0]   wxy_r, wp_r;
  logic [55:0]   acc_r;
  logic [32:0]   inc_r;
  logic [AW-1:0] clr_cnt_r;

  // output register
  logic        out_valid_r;
  logic [47:0] out_density_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  tsc_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // grid memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, cell_addr, rd_addr;
  logic [47:0]   ram_wdata, ram_rdata;

  tsc_ram #(
    .WIDTH (48),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // window start: f + shift - 1.5 cells, Q.32
  logic signed [35:0] win_t;
  assign win_t = $signed({4'h0, mul_p[31:0]})
               + $signed({{2{shift_r[17]}}, shift_r, 16'h0}) - WIN_OFS;

  // base cell remainder: reciprocal quotient estimate, then one correction
  logic [31:0]   rem_raw;
  logic [CW-1:0] rem_val;
  assign rem_raw = base_r - mul_p[31:0];
  assign rem_val = (rem_raw >= 32'(GRID_N)) ? CW'(rem_raw - 32'(GRID_N))
                                            : CW'(rem_raw);

  // first window cell, wrapped once
  logic signed [CW+2:0] fc_sum;
  logic [CW-1:0]        fc_val;
  always_comb begin
    fc_sum = $signed({3'b000, rem_val}) + $signed({{(CW-1){lo_r[3]}}, lo_r});
    if (fc_sum < 0) begin
      fc_val = CW'(fc_sum + $signed((CW+3)'(GRID_N)));
    end else if (fc_sum >= $signed((CW+3)'(GRID_N))) begin
      fc_val = CW'(fc_sum - $signed((CW+3)'(GRID_N)));
    end else begin
      fc_val = fc_sum[CW-1:0];
    end
  end

  // distance of window cell k, f - cell - shift, truncated to Q.24
  logic signed [35:0] dlt_base;
  logic signed [35:0] dlt;
  logic [35:0]        dlt_abs;
  logic [27:0]        d24;
  logic [25:0]        wop;
  logic [23:0]        wgt_val;
  always_comb begin
    dlt_base = $signed({4'h0, frac_r}) - $signed({shift_r[17], shift_r, 17'h0});
    case (k_r)
      2'd0:    dlt = dlt_base + 36'sh1_8000_0000;
      2'd1:    dlt = dlt_base + 36'sh0_8000_0000;
      2'd2:    dlt = dlt_base - 36'sh0_8000_0000;
      default: dlt = dlt_base - 36'sh1_8000_0000;
    endcase
    dlt_abs = dlt[35] ? 36'(-dlt) : dlt;
    d24     = dlt_abs[35:8];
    if (d24 < 28'(HALF_Q24)) begin
      wop = d24[25:0];
    end else if (d24 < 28'(THREEHALF_Q24)) begin
      wop = 26'(28'(THREEHALF_Q24) - d24);
    end else begin
      wop = 26'h0;
    end
    wgt_val = (d24 < 28'(HALF_Q24)) ? 24'(THREEQ_Q24 - mul_p[47:24]) : mul_p[48:25];
  end

  // multiplier operand select
  always_comb begin
    mul_a = 32'h0;
    mul_b = 32'h0;
    unique case (state_r)
      S_GMUL: begin
        mul_a = pos_r[axis_r];
        mul_b = cpl_r;
      end
      S_MOD: begin
        mul_a = mod_ph_r ? quo_r : base_r;
        mul_b = mod_ph_r ? 32'(GRID_N) : RECIP;
      end
      S_WGT: begin
        mul_a = {6'h0, wop};
        mul_b = {6'h0, wop};
      end
      S_MMUL: begin
        mul_a = mass_r;
        mul_b = norm_r;
      end
      S_WXY: begin
        mul_a = {8'h0, wgt_r[0][i_r]};
        mul_b = {8'h0, wgt_r[1][j_r]};
      end
      S_WP: begin
        mul_a = {8'h0, wxy_r};
        mul_b = {8'h0, wgt_r[2][k_r]};
      end
      S_MH: begin
        mul_a = mhi_r;
        mul_b = {8'h0, wp_r};
      end
      S_ML: begin
        mul_a = mlo_r;
        mul_b = {8'h0, wp_r};
      end
      default: begin
        mul_a = 32'h0;
        mul_b = 32'h0;
      end
    endcase
  end

  // cell addresses
  assign cell_addr = {{(AW-CW){1'b0}}, cx_r} * AW'(GRID_N * GRID_N)
                   + {{(AW-CW){1'b0}}, cy_r} * AW'(GRID_N)
                   + {{(AW-CW){1'b0}}, cz_r};
  assign rd_addr   = AW'({17'h0, cell_idx_r});

  // saturating accumulate
  logic [48:0] sum49;
  assign sum49 = {1'b0, ram_rdata} + {16'h0, inc_r};

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_WR);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : cell_addr;
  assign ram_wdata = (state_r == S_CLEAR) ? 48'h0
                   : (sum49[48] ? {48{1'b1}} : sum49[47:0]);
  assign ram_raddr = kind_r ? rd_addr : cell_addr;

  logic rd_oob;
  assign rd_oob = ({17'h0, cell_idx_r} >= 32'(DEPTH));

  logic out_load;
  assign out_load = (state_r == S_RDO) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_nxt = in_kind ? S_RD : S_GMUL;
      end
      S_GMUL: state_nxt = S_MOD;
      S_MOD:  if (mod_ph_r) state_nxt = S_WGT;
      S_WGT: begin
        if (k_r == 2'd3) state_nxt = (axis_r == 2'd2) ? S_MMUL : S_GMUL;
      end
      S_MMUL: state_nxt = S_WXY;
      S_WXY:  state_nxt = S_WP;
      S_WP:   state_nxt = S_MH;
      S_MH:   state_nxt = S_ML;
      S_ML:   state_nxt = S_WR;
      S_WR: begin
        if (k_r != 2'd3) begin
          state_nxt = S_WP;
        end else if (j_r != 2'd3 || i_r != 2'd3) begin
          state_nxt = S_WXY;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD:  state_nxt = S_RDO;
      S_RDO: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= 1'b0;
      cpl_r       <= 32'd65536;
      shift_r     <= 18'sd0;
      norm_r      <= 32'd20698306;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == S_IDLE && in_valid) kind_r <= in_kind;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_CPL:   cpl_r   <= cfg_wdata;
          REG_SHIFT: shift_r <= cfg_wdata[17:0];
          REG_NORM:  norm_r  <= cfg_wdata;
          default:   ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (out_load) out_density_r <= rd_oob ? 48'h0 : ram_rdata;
    unique case (state_r)
      S_IDLE: begin
        pos_r[0]   <= in_pos_x;
        pos_r[1]   <= in_pos_y;
        pos_r[2]   <= in_pos_z;
        mass_r     <= in_mass;
        cell_idx_r <= in_cell_index;
        axis_r     <= 2'd0;
      end
      S_GMUL: begin
        frac_r   <= win_t[31:0];
        lo_r     <= win_t[35:32];
        base_r   <= mul_p[63:32];
        mod_ph_r <= 1'b0;
        k_r      <= 2'd0;
      end
      S_MOD: begin
        mod_ph_r <= 1'b1;
        if (!mod_ph_r) begin
          quo_r <= mul_p[63:32];
        end else begin
          fc_r[axis_r] <= fc_val;
        end
      end
      S_WGT: begin
        wgt_r[axis_r][k_r] <= wgt_val;
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) axis_r <= axis_r + 2'd1;
      end
      S_MMUL: begin
        mhi_r <= mul_p[63:32];
        mlo_r <= mul_p[31:0];
        i_r   <= 2'd0;
        j_r   <= 2'd0;
        k_r   <= 2'd0;
        cx_r  <= fc_r[0];
        cy_r  <= fc_r[1];
        cz_r  <= fc_r[2];
      end
      S_WXY: wxy_r <= mul_p[47:24];
      S_WP:  wp_r  <= mul_p[47:24];
      S_MH:  acc_r <= mul_p[55:0];
      S_ML:  inc_r <= 33'((57'(acc_r) + 57'(mul_p[63:32])) >> 24);
      S_WR: begin
        // step z, then y, then x, each wrapping on the grid
        k_r  <= k_r + 2'd1;
        cz_r <= (cz_r == CW'(GRID_N - 1)) ? '0 : cz_r + 1'b1;
        if (k_r == 2'd3) begin
          cz_r <= fc_r[2];
          j_r  <= j_r + 2'd1;
          cy_r <= (cy_r == CW'(GRID_N - 1)) ? '0 : cy_r + 1'b1;
          if (j_r == 2'd3) begin
            cy_r <= fc_r[1];
            i_r  <= i_r + 2'd1;
            cx_r <= (cx_r == CW'(GRID_N - 1)) ? '0 : cx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_density = out_density_r;

  // checks
  `TSC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `TSC_ASSERT_IMP(a_write_states, ram_we, state_r == S_CLEAR || state_r == S_WR)
  `TSC_ASSERT_IMP(a_result_from_read, $rose(out_valid_r), $past(state_r == S_RDO))

endmodule

// ----- rtl/core/tsc_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tsc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tsc_mul.sv -----
// shared 32 by 32 unsigned multiplier
`timescale 1ns / 1ps
module tsc_mul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // full product
  assign p = {32'h0, a} * {32'h0, b};

endmodule
